@@ rtl/qep_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qep_pkg: shared types and constants for quadratic edge prolongation
// Sample format, the wider sums, the cell control group and the job record
// that the sample chain hands to the emit stage.
// ----------------------------------------------------------------------------
package qep_pkg;

	// Width of one coarse or fine field on the ports.
	localparam int FIELD_BITS  = 32;
	// Bits of a sample that take part in the arithmetic, sign in the top bit.
	localparam int SAMPLE_BITS = 32;
	// Three times a sample needs two extra bits.
	localparam int TRIPLE_BITS = SAMPLE_BITS + 2;
	// The weighted sums 3a + 6b - c and -a + 6b + 3c fit in four extra bits.
	localparam int SUM_BITS    = SAMPLE_BITS + 4;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [TRIPLE_BITS-1:0] triple_t;
	typedef logic signed [SUM_BITS-1:0]    sum_t;

	// Control shared by every cell of the sample chain.
	typedef struct packed {
		logic shift;
		logic clear;
	} qep_ctrl_t;

	// Everything the emit stage needs for one coarse sample's results.
	typedef struct packed {
		sample_t a;
		triple_t a3;
		sample_t b;
		triple_t b3;
		sample_t c;
		logic    last;
	} qep_job_t;

endpackage

@@ rtl/quadratic_edge_prolongation.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_edge_prolongation: 1-D quadratic prolongation of a coarse row
// Streams signed Q16.16 coarse samples and emits the interior fine values
// of the doubled row.
// ----------------------------------------------------------------------------
// A user should know the following first. Coarse samples of one row enter
// one per transfer on the coarse channel, with end_of_row set on the last
// one. The first two samples of a row only fill the chain. Every later
// sample c produces two fine transfers: the midpoint (3a + 6b - c) / 8 and
// then a copy of b, where a and b are the two samples before c. The last
// sample of a row produces a third transfer, the end midpoint
// (-a + 6b + 3c) / 8, flagged with row_done. Division by eight rounds toward
// minus infinity and midpoints saturate to the 32-bit signed range; copies
// carry is_copy. A row of fewer than three samples produces nothing. Row
// endpoints are not produced. Timing: the fine output register sends one
// transfer per cycle when the fine side does not stall, and the first
// result is offered once the sample has passed the job register and the
// output register. A new coarse sample is taken in the cycle in which
// the last result of the previous one moves into the output register, so
// the chain and the sequencer work on neighboring samples at the same
// time. Samples that only fill the chain need no sequencer time; once the
// sequencer is idle they are taken in consecutive cycles.
// ----------------------------------------------------------------------------
module quadratic_edge_prolongation (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      coarse_valid,
	output logic                                      coarse_stall,
	input  logic signed [qep_pkg::FIELD_BITS-1:0]     coarse_value,
	input  logic                                      end_of_row,
	output logic                                      fine_valid,
	input  logic                                      fine_stall,
	output logic signed [qep_pkg::FIELD_BITS-1:0]     fine_value,
	output logic                                      is_copy,
	output logic                                      row_done
);
	import qep_pkg::*;

	// Handshake on the coarse side.
	logic      accept;
	logic      job_free;
	logic      job_load;

	// Sample chain: cell 0 holds the newer sample b, cell 1 the older a.
	// Their valid flags together count the samples held, up to two.
	qep_ctrl_t ctrl;
	sample_t   sample_in;
	logic      newer_valid;
	sample_t   newer_value;
	triple_t   newer_triple;
	logic      older_valid;
	sample_t   older_value;
	triple_t   older_triple;

	qep_job_t  job;
	sample_t   fine_sample;

	// Only the low sample bits of the port take part, sign from the top one.
	assign sample_in = $signed(SAMPLE_BITS'($unsigned(coarse_value)));

	assign coarse_stall = !job_free;
	assign accept       = coarse_valid && !coarse_stall;

	// A sample starts a job once two samples are held; the chain then shifts,
	// or clears at the end of a row, short rows included.
	assign job_load   = accept && older_valid;
	assign ctrl.shift = accept && !end_of_row;
	assign ctrl.clear = accept && end_of_row;

	qep_cell u_cell_newer (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.d_valid (1'b1),
		.d       (sample_in),
		.valid   (newer_valid),
		.value   (newer_value),
		.triple  (newer_triple)
	);

	qep_cell u_cell_older (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.d_valid (newer_valid),
		.d       (newer_value),
		.valid   (older_valid),
		.value   (older_value),
		.triple  (older_triple)
	);

	// Snapshot of the chain and the incoming sample for the sequencer.
	assign job.a    = older_value;
	assign job.a3   = older_triple;
	assign job.b    = newer_value;
	assign job.b3   = newer_triple;
	assign job.c    = sample_in;
	assign job.last = end_of_row;

	qep_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (job_load),
		.job        (job),
		.job_free   (job_free),
		.fine_stall (fine_stall),
		.fine_valid (fine_valid),
		.fine_value (fine_sample),
		.is_copy    (is_copy),
		.row_done   (row_done)
	);

	assign fine_value = $signed(FIELD_BITS'($unsigned(fine_sample)));

endmodule

@@ rtl/qep_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qep_cell: one cell of the coarse sample chain
// Holds one sample, its triple and a valid flag, and takes its neighbor's
// contents whenever the chain shifts.
// ----------------------------------------------------------------------------
module qep_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  qep_pkg::qep_ctrl_t ctrl,
	input  logic               d_valid,
	input  qep_pkg::sample_t   d,
	output logic               valid,
	output qep_pkg::sample_t   value,
	output qep_pkg::triple_t   triple
);
	import qep_pkg::*;

	logic    valid_q;
	sample_t value_q;
	triple_t triple_q;
	triple_t d_ext;

	assign d_ext = TRIPLE_BITS'(d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= d_valid;
		end
	end

	// The triple is formed on the way in, so the emit stage only adds.
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			value_q  <= d;
			triple_q <= d_ext + (d_ext <<< 1);
		end
	end

	assign valid  = valid_q;
	assign value  = value_q;
	assign triple = triple_q;

endmodule

@@ rtl/qep_emit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qep_emit: result sequencer and output register
// Steps through midpoint, copy and, on a row's last sample, end midpoint
// of one job, forms the weighted sum, divides by eight with floor and saturates.
// ----------------------------------------------------------------------------
module qep_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  qep_pkg::qep_job_t job,
	output logic              job_free,
	input  logic              fine_stall,
	output logic              fine_valid,
	output qep_pkg::sample_t  fine_value,
	output logic              is_copy,
	output logic              row_done
);
	import qep_pkg::*;

	typedef enum logic [2:0] {
		PH_MID  = 3'b001,
		PH_COPY = 3'b010,
		PH_END  = 3'b100
	} phase_t;

	localparam sample_t SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam sample_t SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	phase_t   phase_q;
	phase_t   phase_next;
	logic     job_valid_q;
	qep_job_t job_q;
	triple_t  c3_q;
	logic     fine_valid_q;
	sample_t  fine_value_q;
	logic     is_copy_q;
	logic     row_done_q;

	logic                 out_load;
	logic                 final_step;
	sum_t                 term_pos;
	sum_t                 term_neg;
	sum_t                 sum;
	logic [SAMPLE_BITS:0] quot;
	sample_t              mid_sat;
	sample_t              result;
	triple_t              c_ext;

	assign c_ext = TRIPLE_BITS'(job.c);

	assign out_load   = job_valid_q && (!fine_valid_q || !fine_stall);
	assign final_step = (phase_q == PH_END) || ((phase_q == PH_COPY) && !job_q.last);
	assign job_free   = !job_valid_q || (out_load && final_step);

	always_comb begin
		unique case (phase_q)
			PH_MID:  phase_next = PH_COPY;
			PH_COPY: phase_next = PH_END;
			PH_END:  phase_next = PH_MID;
			default: phase_next = PH_MID;
		endcase
	end

	// Midpoint toward b: 3a + 6b - c. End midpoint: 3c + 6b - a.
	always_comb begin
		if (phase_q == PH_END) begin
			term_pos = SUM_BITS'(c3_q);
			term_neg = SUM_BITS'(job_q.a);
		end else begin
			term_pos = SUM_BITS'(job_q.a3);
			term_neg = SUM_BITS'(job_q.c);
		end
		sum  = term_pos + (SUM_BITS'(job_q.b3) <<< 1) - term_neg;
		// Dropping three low bits is a floor division by eight.
		quot = sum[SUM_BITS-1:3];
		if (quot[SAMPLE_BITS] != quot[SAMPLE_BITS-1]) begin
			mid_sat = quot[SAMPLE_BITS] ? SAT_MIN : SAT_MAX;
		end else begin
			mid_sat = quot[SAMPLE_BITS-1:0];
		end
		result = (phase_q == PH_COPY) ? job_q.b : mid_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			phase_q     <= PH_MID;
		end else if (load) begin
			job_valid_q <= 1'b1;
			phase_q     <= PH_MID;
		end else if (out_load && final_step) begin
			job_valid_q <= 1'b0;
			phase_q     <= PH_MID;
		end else if (out_load) begin
			phase_q <= phase_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fine_valid_q <= 1'b0;
		end else if (out_load) begin
			fine_valid_q <= 1'b1;
		end else if (!fine_stall) begin
			fine_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_q <= job;
			c3_q  <= c_ext + (c_ext <<< 1);
		end
		if (out_load) begin
			fine_value_q <= result;
			is_copy_q    <= (phase_q == PH_COPY);
			row_done_q   <= (phase_q == PH_END);
		end
	end

	assign fine_valid = fine_valid_q;
	assign fine_value = fine_value_q;
	assign is_copy    = is_copy_q;
	assign row_done   = row_done_q;

endmodule
